>>> design/fip_pkg.sv
// ----------------------------------------------------------------------------
// fip_pkg
// Shared types and constants for the integer power of a binary64 value.
// ----------------------------------------------------------------------------
package fip_pkg;

  // width of the signed exponent operand
  localparam int EXP_WIDTH = 16;
  // loop count holds the full magnitude of the most negative exponent
  localparam int CNT_W     = EXP_WIDTH + 1;

  // binary64 encodings
  localparam logic [63:0] FP_ONE    = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] FP_ZERO   = 64'h0000_0000_0000_0000;
  localparam logic [10:0] EXP_ALL1  = 11'h7FF;
  localparam int          QUIET_BIT = 51;

  // number of quotient bits produced by the reciprocal unit
  localparam int          QBITS     = 57;

  typedef struct packed {
    logic [63:0]                  base_bits;
    logic signed [EXP_WIDTH-1:0]  exponent;
  } fip_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        undefined_flag;
  } fip_out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic norm_base;
    logic mul_step;
    logic mul_round;
    logic norm_acc;
    logic div_start;
    logic div_step;
    logic div_round;
  } fip_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic special;
    logic base_norm;
    logic mul_last;
    logic acc_norm;
    logic acc_stop;
    logic count_zero;
    logic neg;
    logic div_last;
  } fip_sts_t;

  // output of the round and pack unit
  typedef struct packed {
    logic                inf;
    logic                zero;
    logic [52:0]         mant;
    logic signed [12:0]  exp;
    logic [10:0]         efield;
    logic [51:0]         frac;
  } fip_rnd_t;

endpackage

>>> design/float_integer_power.sv
// ----------------------------------------------------------------------------
// float_integer_power
// Raises a binary64 base to a signed integer power by repeated rounded
// multiplication, with one rounded reciprocal for negative powers.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; the result
// appears for one cycle with done high and must be captured then, as the
// block cannot be stalled. Special operands (zero base, zero power, NaN,
// infinity) go straight from load to done. Otherwise each of up to |exponent|
// multiplies uses one 27x27 multiplier over four passes, then a round step
// and a check step. A subnormal base or intermediate is shifted up one bit
// per step until normal (at most 52 shifts each time). A negative power
// then runs the bit-serial reciprocal divider and a final rounding step.
// ----------------------------------------------------------------------------
module float_integer_power import fip_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  fip_in_t  operand,
  output logic     done,
  output fip_out_t result
);

  fip_cmd_t cmd;
  fip_sts_t sts;

  // sequencer
  fip_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // arithmetic
  fip_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

endmodule

>>> design/fip_ctrl.sv
// ----------------------------------------------------------------------------
// fip_ctrl
// Sequencer: steps the datapath through load, repeated multiply and the
// optional reciprocal.
// ----------------------------------------------------------------------------
module fip_ctrl import fip_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  fip_sts_t sts,
  output fip_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_NORMB = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_RND   = 8'b0000_1000,
    S_NORMA = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_DRND  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_NORMB;
        end
      end
      S_NORMB: begin
        if (sts.special) begin
          state_next = S_DONE;
        end else if (sts.base_norm) begin
          state_next = S_MUL;
        end else begin
          cmd.norm_base = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          state_next = S_RND;
        end
      end
      S_RND: begin
        cmd.mul_round = 1'b1;
        state_next    = S_NORMA;
      end
      S_NORMA: begin
        if (!sts.acc_norm) begin
          cmd.norm_acc = 1'b1;
        end else if (sts.count_zero || sts.acc_stop) begin
          if (sts.neg && !sts.acc_stop) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          state_next = S_MUL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DRND;
        end
      end
      S_DRND: begin
        cmd.div_round = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

>>> design/fip_dp.sv
// ----------------------------------------------------------------------------
// fip_dp
// Datapath: operand decode, split multiplier, round and pack unit,
// normalising shifter and restoring reciprocal divider.
// ----------------------------------------------------------------------------
module fip_dp import fip_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  fip_in_t  operand,
  input  fip_cmd_t cmd,
  output fip_sts_t sts,
  output fip_out_t result
);

  // round a 106-bit significand product to binary64, nearest even
  function automatic fip_rnd_t round_pack(input logic [105:0] p,
                                          input logic signed [12:0] e);
    logic               hi;
    logic [105:0]       n;
    logic signed [12:0] e1, e2, e3, sh, ef;
    logic [6:0]         sc;
    logic [211:0]       wide;
    logic [105:0]       ns;
    logic               stk, g, st, up;
    logic [52:0]        m, mf;
    logic [53:0]        mr;
    fip_rnd_t           r;
    hi = p[105];
    n  = hi ? p : {p[104:0], 1'b0};
    e1 = hi ? e + 13'sd1 : e;
    if (e1 < -13'sd1022) begin
      sh = -13'sd1022 - e1;
      sc = (sh > 13'sd107) ? 7'd107 : sh[6:0];
      e2 = -13'sd1022;
    end else begin
      sh = 13'sd0;
      sc = 7'd0;
      e2 = e1;
    end
    wide = {n, 106'd0} >> sc;
    ns   = wide[211:106];
    stk  = |wide[105:0];
    m    = ns[105:53];
    g    = ns[52];
    st   = (|ns[51:0]) | stk;
    up   = g & (st | m[0]);
    mr   = {1'b0, m} + {53'd0, up};
    if (mr[53]) begin
      mf = mr[53:1];
      e3 = e2 + 13'sd1;
    end else begin
      mf = mr[52:0];
      e3 = e2;
    end
    ef       = e3 + 13'sd1023;
    r.inf    = (e3 > 13'sd1023);
    r.zero   = (mf == 53'd0);
    r.mant   = mf;
    r.exp    = e3;
    r.efield = mf[52] ? ef[10:0] : 11'd0;
    r.frac   = mf[51:0];
    return r;
  endfunction

  // operand decode
  logic [10:0]          in_exp;
  logic [51:0]          in_frac;
  logic                 in_zero, in_nan, in_inf, in_neg, in_exp_zero, in_sign;
  logic [CNT_W-1:0]     in_mag;
  logic [EXP_WIDTH-1:0] in_raw;

  assign in_exp      = operand.base_bits[62:52];
  assign in_frac     = operand.base_bits[51:0];
  assign in_raw      = operand.exponent;
  assign in_zero     = (in_exp == 11'd0) && (in_frac == 52'd0);
  assign in_nan      = (in_exp == EXP_ALL1) && (in_frac != 52'd0);
  assign in_inf      = (in_exp == EXP_ALL1) && (in_frac == 52'd0);
  assign in_neg      = in_raw[EXP_WIDTH-1];
  assign in_exp_zero = (in_raw == '0);
  assign in_mag      = in_neg ? -{in_raw[EXP_WIDTH-1], in_raw} : {1'b0, in_raw};
  assign in_sign     = operand.base_bits[63] & in_mag[0];

  // working registers
  logic                special, neg, sgn, undef;
  logic [CNT_W-1:0]    count;
  logic [52:0]         mb, ma;
  logic signed [12:0]  eb, ea;
  logic                acc_zero, acc_inf;
  logic [105:0]        prod;
  logic [1:0]          pidx;
  logic [53:0]         rem;
  logic [QBITS-1:0]    quo;
  logic [5:0]          didx;
  logic [63:0]         res;

  // partial product selection, 27 by 27 bits
  logic [26:0]  opa, opb;
  logic [53:0]  pp;
  logic [105:0] pp_sh;

  assign opa = pidx[1] ? ma[52:26] : {1'b0, ma[25:0]};
  assign opb = pidx[0] ? mb[52:26] : {1'b0, mb[25:0]};
  assign pp  = opa * opb;

  always_comb begin
    case (pidx)
      2'd0:    pp_sh = {52'd0, pp};
      2'd1,
      2'd2:    pp_sh = {26'd0, pp, 26'd0};
      2'd3:    pp_sh = {pp[53:0], 52'd0};
      default: pp_sh = {52'd0, pp};
    endcase
  end

  // round units for the product and the reciprocal
  fip_rnd_t rm, rd;
  logic [105:0] dp_in;

  assign dp_in = {quo, 49'd0} | {105'd0, (rem != 54'd0)};
  assign rm    = round_pack(prod, ea + eb);
  assign rd    = round_pack(dp_in, -ea - 13'sd1);

  // reciprocal subtract
  logic        ge;
  logic [53:0] rem_sub;

  assign ge      = (rem >= {1'b0, ma});
  assign rem_sub = ge ? rem - {1'b0, ma} : rem;

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      special  <= 1'b0;
      neg      <= 1'b0;
      acc_zero <= 1'b0;
      acc_inf  <= 1'b0;
      pidx     <= 2'd0;
      didx     <= 6'd0;
      count    <= '0;
    end else begin
      if (cmd.load) begin
        special  <= in_zero || in_exp_zero || in_nan || in_inf;
        neg      <= in_neg;
        acc_zero <= 1'b0;
        acc_inf  <= 1'b0;
        pidx     <= 2'd0;
        count    <= in_mag;
      end
      if (cmd.mul_step) begin
        pidx <= pidx + 2'd1;
      end
      if (cmd.mul_round) begin
        acc_zero <= rm.zero;
        acc_inf  <= rm.inf;
        count    <= count - CNT_W'(1);
      end
      if (cmd.div_start) begin
        didx <= 6'd0;
      end
      if (cmd.div_step) begin
        didx <= didx + 6'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    // operand load and special results
    if (cmd.load) begin
      sgn   <= in_sign;
      undef <= in_zero && in_exp_zero;
      ma    <= {1'b1, 52'd0};
      ea    <= 13'sd0;
      prod  <= '0;
      if (in_exp == 11'd0) begin
        mb <= {1'b0, in_frac};
        eb <= -13'sd1022;
      end else begin
        mb <= {1'b1, in_frac};
        eb <= $signed({2'b00, in_exp}) - 13'sd1023;
      end
      if (in_zero && in_exp_zero) begin
        res <= FP_ONE;
      end else if (in_zero) begin
        res <= FP_ZERO;
      end else if (in_exp_zero) begin
        res <= FP_ONE;
      end else if (in_nan) begin
        res <= operand.base_bits | (64'd1 << QUIET_BIT);
      end else if (in_neg) begin
        res <= {in_sign, 63'd0};
      end else begin
        res <= {in_sign, EXP_ALL1, 52'd0};
      end
    end
    // normalise a subnormal base
    if (cmd.norm_base) begin
      mb <= {mb[51:0], 1'b0};
      eb <= eb - 13'sd1;
    end
    // accumulate one partial product
    if (cmd.mul_step) begin
      prod <= prod + pp_sh;
    end
    // round the product into the accumulator
    if (cmd.mul_round) begin
      ma   <= rm.mant;
      ea   <= rm.exp;
      prod <= '0;
      if (!neg) begin
        res <= rm.inf ? {sgn, EXP_ALL1, 52'd0} : {sgn, rm.efield, rm.frac};
      end else begin
        res <= rm.inf ? {sgn, 63'd0} : {sgn, EXP_ALL1, 52'd0};
      end
    end
    // normalise a subnormal accumulator
    if (cmd.norm_acc) begin
      ma <= {ma[51:0], 1'b0};
      ea <= ea - 13'sd1;
    end
    // restoring reciprocal, one quotient bit a cycle
    if (cmd.div_start) begin
      rem <= {2'b01, 52'd0};
      quo <= '0;
    end
    if (cmd.div_step) begin
      rem <= {rem_sub[52:0], 1'b0};
      quo <= {quo[QBITS-2:0], ge};
    end
    if (cmd.div_round) begin
      res <= rd.inf ? {sgn, EXP_ALL1, 52'd0} : {sgn, rd.efield, rd.frac};
    end
  end

  // status back to the controller
  assign sts.special    = special;
  assign sts.base_norm  = mb[52];
  assign sts.mul_last   = (pidx == 2'd3);
  assign sts.acc_norm   = ma[52] | acc_zero | acc_inf;
  assign sts.acc_stop   = acc_zero | acc_inf;
  assign sts.count_zero = (count == '0);
  assign sts.neg        = neg;
  assign sts.div_last   = (didx == 6'(QBITS - 1));

  assign result.result_bits    = res;
  assign result.undefined_flag = undef;

endmodule
